[hw/rtl/csfk_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csfk_pkg
// Shared constants, types and fixed-point helpers of the segment kinematics.
// ----------------------------------------------------------------------------
package csfk_pkg;

  localparam int PW = 34;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LENGTH     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_THRESHOLD = 1'b1;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint KINF_Q30    = 64'sd652032874;
  localparam longint KCORR_Q30   = 64'sd434688583;
  localparam longint POS_MAX     = 64'sd65535;
  localparam longint ROT_MAX     = 64'sd16384;

  localparam longint ATAN_Q30 [24] = '{
    64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
    64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
    64'sd4194283, 64'sd2097149, 64'sd1048576, 64'sd524288,
    64'sd262144, 64'sd131072, 64'sd65536, 64'sd32768,
    64'sd16384, 64'sd8192, 64'sd4096, 64'sd2048,
    64'sd1024, 64'sd512, 64'sd256, 64'sd128
  };

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } rot_t;

  // Q30 product with rounding to nearest, ties toward plus infinity.
  function automatic logic signed [PW-1:0] mulq(input logic signed [PW-1:0] a,
                                                input logic signed [PW-1:0] b);
    logic signed [2*PW-1:0] p;
    p = a * b;
    p = p + (2*PW)'(64'sd536870912);
    return PW'(p >>> 30);
  endfunction

  // Q30 value to clamped Q1.14.
  function automatic logic signed [15:0] rot_round(input logic signed [PW+1:0] v);
    logic signed [PW+1:0] t;
    t = (v + (PW+2)'(64'sd32768)) >>> 16;
    if (t > (PW+2)'(ROT_MAX)) begin
      t = (PW+2)'(ROT_MAX);
    end else if (t < -(PW+2)'(ROT_MAX)) begin
      t = -(PW+2)'(ROT_MAX);
    end
    return 16'(t);
  endfunction

endpackage
`default_nettype wire

[hw/rtl/csfk_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csfk_cordic
// Pipelined sine and cosine: range reduction, quadrant fold and one
// rotation-mode CORDIC iteration per register stage.
// ----------------------------------------------------------------------------
module csfk_cordic #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int TRIG_STAGES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [15:0]             angle,
  output logic signed [csfk_pkg::PW-1:0]      sin_out,
  output logic signed [csfk_pkg::PW-1:0]      cos_out
);

  localparam int PW = csfk_pkg::PW;
  localparam int S  = 30 - ANGLE_FRAC_BITS;
  localparam int AW = (17 + S > 35) ? 17 + S : 35;
  localparam int RS = (AW > 34) ? AW - 33 : 1;
  localparam logic signed [AW-1:0] PI_A     = AW'(csfk_pkg::PI_Q30);
  localparam logic signed [AW-1:0] TWO_PI_A = AW'(csfk_pkg::TWO_PI_Q30);
  localparam logic signed [PW-1:0] PI_P     = PW'(csfk_pkg::PI_Q30);
  localparam logic signed [PW-1:0] HP_P     = PW'(csfk_pkg::HALF_PI_Q30);
  localparam longint KINIT = csfk_pkg::KINF_Q30 + (csfk_pkg::KCORR_Q30 >>> (2 * TRIG_STAGES));

  logic signed [AW-1:0] a_in;
  logic signed [AW-1:0] red;
  logic signed [PW-1:0] a_r;
  logic signed [PW-1:0] xs [0:TRIG_STAGES];
  logic signed [PW-1:0] ys [0:TRIG_STAGES];
  logic signed [PW-1:0] zs [0:TRIG_STAGES];
  logic                 ng [0:TRIG_STAGES];

  assign a_in = AW'(angle) <<< S;

  always_comb begin
    logic signed [AW-1:0] c;
    logic hi;
    logic lo;
    hi = a_in > PI_A;
    lo = a_in < -PI_A;
    c = hi ? a_in - PI_A - AW'(1) : -PI_A - a_in - AW'(1);
    for (int j = RS - 1; j >= 0; j--) begin
      if (c >= (TWO_PI_A <<< j)) begin
        c = c - (TWO_PI_A <<< j);
      end
    end
    if (hi) begin
      red = c - PI_A + AW'(1);
    end else if (lo) begin
      red = PI_A - AW'(1) - c;
    end else begin
      red = a_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= PW'(red);
      xs[0] <= PW'(KINIT);
      ys[0] <= '0;
      if (a_r > HP_P) begin
        zs[0] <= a_r - PI_P;
        ng[0] <= 1'b1;
      end else if (a_r < -HP_P) begin
        zs[0] <= a_r + PI_P;
        ng[0] <= 1'b1;
      end else begin
        zs[0] <= a_r;
        ng[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        ng[i+1] <= ng[i];
        if (!zs[i][PW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - PW'(csfk_pkg::ATAN_Q30[i]);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + PW'(csfk_pkg::ATAN_Q30[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_out <= ng[TRIG_STAGES] ? -ys[TRIG_STAGES] : ys[TRIG_STAGES];
      cos_out <= ng[TRIG_STAGES] ? -xs[TRIG_STAGES] : xs[TRIG_STAGES];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/csfk_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csfk_div
// Pipelined restoring divider: rounded magnitude quotient, one quotient bit
// per stage, saturated to 65535 and given the requested sign.
// ----------------------------------------------------------------------------
module csfk_div #(
  parameter int NW = 51,
  parameter int UDW = 31
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [NW-1:0]  num,
  input  wire logic [UDW-1:0]        den,
  input  wire logic                  neg,
  output logic signed [16:0]         quo
);

  localparam int QB = 17;
  localparam int RW = ((NW - 1 > UDW + QB) ? NW - 1 : UDW + QB) + 1;

  logic [NW-1:0]  mag;
  logic [RW-1:0]  rem [0:QB];
  logic [UDW-1:0] dv  [0:QB];
  logic [QB-1:0]  q   [0:QB];
  logic           ng  [0:QB];
  logic           ov  [0:QB];
  logic [15:0]    qs;

  assign mag = num[NW-1] ? NW'(-num) : NW'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(mag) + RW'(den >> 1);
      dv[0]  <= den;
      q[0]   <= '0;
      ng[0]  <= neg;
      ov[0]  <= 1'b0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_bit
    localparam int J = QB - 1 - k;
    logic cmp;
    assign cmp = rem[k] >= (RW'(dv[k]) << J);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= cmp ? rem[k] - (RW'(dv[k]) << J) : rem[k];
        q[k+1]   <= q[k] | (QB'(cmp) << J);
        dv[k+1]  <= dv[k];
        ng[k+1]  <= ng[k];
        if (k == 0) begin
          ov[k+1] <= rem[k] >= (RW'(dv[k]) << QB);
        end else begin
          ov[k+1] <= ov[k];
        end
      end
    end
  end

  assign qs = (ov[QB] || q[QB][QB-1]) ? 16'hFFFF : q[QB][15:0];

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= ng[QB] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
    end
  end

endmodule
`default_nettype wire

[hw/rtl/continuum_segment_forward_kinematics_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// continuum_segment_forward_kinematics_unit
// Tip position and rotation of a constant-curvature continuum segment.
// ----------------------------------------------------------------------------
// The unit takes one segment configuration per clock and returns one result
// per configuration, in order. Each configuration passes through the CORDIC
// iterations (one per stage), the multiply stages, the divider pipeline that
// forms the arc position with its 17 quotient-bit stages, and the output
// register. The whole pipeline holds while a result waits on the output, so
// input transfers pause only while the output is stalled.
module continuum_segment_forward_kinematics_unit #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int TRIG_STAGES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // bend_angle[14:0], plane_angle[30:15], zero pad
  input  wire logic [31:0]                       s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // tip_x, tip_y, tip_z (17 bits each), rot_00, rot_01, rot_02, rot_10,
  // rot_11, rot_12, rot_20, rot_21, rot_22 (16 bits each), zero pad
  output logic [199:0]                           m_tdata,
  input  wire logic                              cfg_wr_en,
  input  wire logic [csfk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [15:0]                       cfg_data
);

  localparam int PW = csfk_pkg::PW;
  localparam int S = 30 - ANGLE_FRAC_BITS;
  localparam longint SCALE = 64'sd1 <<< S;
  localparam longint HP_RAW = (csfk_pkg::HALF_PI_Q30 + (SCALE >>> 1)) / SCALE;
  localparam int DWD = (ANGLE_FRAC_BITS + 2 > 16) ? ANGLE_FRAC_BITS + 2 : 16;
  localparam int UDW = DWD - 1 + S;
  localparam int NW = 17 + PW;
  localparam int CL = TRIG_STAGES + 3;
  localparam int DL = 19;
  localparam int LAT = CL + 3 + DL;

  logic [15:0] segment_length;
  logic [13:0] straight_threshold;
  logic        en;
  logic [LAT-1:0] v;

  logic signed [15:0] theta_in;
  logic signed [15:0] delta_in;
  logic signed [DWD-1:0] d_p [0:CL-1];

  logic signed [PW-1:0] st;
  logic signed [PW-1:0] ct;
  logic signed [PW-1:0] sd;
  logic signed [PW-1:0] cd;
  logic signed [PW-1:0] om;
  logic signed [DWD-1:0] d_c;
  logic [DWD-2:0] ad_c;

  logic signed [PW-1:0] st1, ct1, cc1, ss1, sc1, cdct1, sdct1, pxo1, pyo1;
  logic straight1, dneg1;
  logic [UDW-1:0] ud1;

  logic signed [PW+1:0] r00_2, r01_2, r11_2, r02_2, r12_2, r20_2, r21_2, r22_2;
  logic signed [NW-1:0] nx2, ny2, nz2;
  logic xneg2, yneg2, zneg2, straight2;
  logic [UDW-1:0] ud2;
  logic signed [NW-1:0] len_s;
  logic signed [NW-1:0] nx_c, ny_c, nz_c;

  csfk_pkg::rot_t rot_p [0:DL-1];
  logic st_p [0:DL-1];
  logic signed [16:0] qx, qy, qz;

  logic signed [16:0] tip_x, tip_y, tip_z;
  csfk_pkg::rot_t rot_o;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = v[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_length <= '0;
      straight_threshold <= 14'd29;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        csfk_pkg::REG_SEGMENT_LENGTH:     segment_length <= cfg_data;
        csfk_pkg::REG_STRAIGHT_THRESHOLD: straight_threshold <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAT-2:0], s_tvalid};
    end
  end

  assign theta_in = $signed({1'b0, s_tdata[14:0]});
  assign delta_in = $signed(s_tdata[30:15]);

  csfk_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TRIG_STAGES(TRIG_STAGES)) u_theta (
    .clk(clk), .en(en), .angle(theta_in), .sin_out(st), .cos_out(ct)
  );

  csfk_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TRIG_STAGES(TRIG_STAGES)) u_delta (
    .clk(clk), .en(en), .angle(delta_in), .sin_out(sd), .cos_out(cd)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      d_p[0] <= DWD'(theta_in) - DWD'(HP_RAW);
      for (int k = 1; k < CL; k++) begin
        d_p[k] <= d_p[k-1];
      end
    end
  end

  assign d_c  = d_p[CL-1];
  assign ad_c = d_c[DWD-1] ? (DWD-1)'(-d_c) : (DWD-1)'(d_c);
  assign om   = PW'(csfk_pkg::Q30_ONE) - st;

  always_ff @(posedge clk) begin
    if (en) begin
      st1   <= st;
      ct1   <= ct;
      cc1   <= csfk_pkg::mulq(cd, cd);
      ss1   <= csfk_pkg::mulq(sd, sd);
      sc1   <= csfk_pkg::mulq(sd, cd);
      cdct1 <= csfk_pkg::mulq(cd, ct);
      sdct1 <= csfk_pkg::mulq(sd, ct);
      pxo1  <= csfk_pkg::mulq(cd, om);
      pyo1  <= csfk_pkg::mulq(sd, om);
      straight1 <= {1'b0, ad_c} <= DWD'(straight_threshold);
      dneg1 <= d_c[DWD-1];
      ud1   <= UDW'(ad_c) << S;
    end
  end

  assign len_s = NW'($signed({1'b0, segment_length}));
  assign nx_c = len_s * NW'(pxo1);
  assign ny_c = len_s * NW'(pyo1);
  assign nz_c = len_s * NW'(ct1);

  always_ff @(posedge clk) begin
    if (en) begin
      r00_2 <= (PW+2)'(csfk_pkg::mulq(st1, cc1)) + (PW+2)'(ss1);
      r01_2 <= (PW+2)'(sc1) - (PW+2)'(csfk_pkg::mulq(st1, sc1));
      r11_2 <= (PW+2)'(csfk_pkg::mulq(st1, ss1)) + (PW+2)'(cc1);
      r02_2 <= (PW+2)'(cdct1);
      r12_2 <= -(PW+2)'(sdct1);
      r20_2 <= -(PW+2)'(cdct1);
      r21_2 <= (PW+2)'(sdct1);
      r22_2 <= (PW+2)'(st1);
      nx2 <= nx_c;
      ny2 <= ny_c;
      nz2 <= nz_c;
      xneg2 <= !(nx_c[NW-1] ^ dneg1);
      yneg2 <= ny_c[NW-1] ^ dneg1;
      zneg2 <= !(nz_c[NW-1] ^ dneg1);
      ud2 <= ud1;
      straight2 <= straight1;
    end
  end

  csfk_div #(.NW(NW), .UDW(UDW)) u_div_x (
    .clk(clk), .en(en), .num(nx2), .den(ud2), .neg(xneg2), .quo(qx)
  );
  csfk_div #(.NW(NW), .UDW(UDW)) u_div_y (
    .clk(clk), .en(en), .num(ny2), .den(ud2), .neg(yneg2), .quo(qy)
  );
  csfk_div #(.NW(NW), .UDW(UDW)) u_div_z (
    .clk(clk), .en(en), .num(nz2), .den(ud2), .neg(zneg2), .quo(qz)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      rot_p[0].r00 <= csfk_pkg::rot_round(r00_2);
      rot_p[0].r01 <= csfk_pkg::rot_round(r01_2);
      rot_p[0].r02 <= csfk_pkg::rot_round(r02_2);
      rot_p[0].r10 <= csfk_pkg::rot_round(r01_2);
      rot_p[0].r11 <= csfk_pkg::rot_round(r11_2);
      rot_p[0].r12 <= csfk_pkg::rot_round(r12_2);
      rot_p[0].r20 <= csfk_pkg::rot_round(r20_2);
      rot_p[0].r21 <= csfk_pkg::rot_round(r21_2);
      rot_p[0].r22 <= csfk_pkg::rot_round(r22_2);
      st_p[0] <= straight2;
      for (int k = 1; k < DL; k++) begin
        rot_p[k] <= rot_p[k-1];
        st_p[k] <= st_p[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_o <= rot_p[DL-1];
      if (st_p[DL-1]) begin
        tip_x <= '0;
        tip_y <= '0;
        tip_z <= $signed({1'b0, segment_length});
      end else begin
        tip_x <= qx;
        tip_y <= qy;
        tip_z <= qz;
      end
    end
  end

  assign m_tdata = {5'b0, rot_o.r22, rot_o.r21, rot_o.r20, rot_o.r12, rot_o.r11,
                    rot_o.r10, rot_o.r02, rot_o.r01, rot_o.r00, tip_z, tip_y, tip_x};

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v))
    else $error("pipeline valid bits moved during a stall");

  a_straight: assert property (@(posedge clk) disable iff (rst)
    en && v[LAT-2] && st_p[DL-1] |=> tip_x == 17'sd0 && tip_y == 17'sd0)
    else $error("straight segment gave a lateral offset");

  a_rot_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> rot_o.r22 <= 16'sd16384 && rot_o.r22 >= -16'sd16384 &&
                 rot_o.r00 <= 16'sd16384 && rot_o.r00 >= -16'sd16384)
    else $error("rotation entry outside the unit range");

endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the continuum segment kinematics unit against its own predictor of
// tip position and rotation, under random idling and a long output stall.
// ----------------------------------------------------------------------------

class tip_pose_scoreboard;
  localparam int FRAC = 13;
  localparam int STAGES = 16;

  logic [199:0] pose_q[$];
  longint       seg_len;
  longint       straight_thr;
  int           mismatches;
  int           checked;

  function void reset_regs();
    seg_len = 0;
    straight_thr = 29;
  endfunction

  function void write_reg(logic idx, logic [15:0] value);
    if (idx == csfk_pkg::REG_SEGMENT_LENGTH) begin
      seg_len = value;
    end else begin
      straight_thr = value & 16'h3FFF;
    end
  endfunction

  function longint q30_mul(longint a, longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function void sin_cos_q30(longint ang, output longint sn, output longint cs);
    longint x, y, t;
    bit flip;
    flip = 0;
    while (ang > csfk_pkg::PI_Q30) ang -= csfk_pkg::TWO_PI_Q30;
    while (ang < -csfk_pkg::PI_Q30) ang += csfk_pkg::TWO_PI_Q30;
    if (ang > csfk_pkg::HALF_PI_Q30) begin
      ang -= csfk_pkg::PI_Q30;
      flip = 1;
    end else if (ang < -csfk_pkg::HALF_PI_Q30) begin
      ang += csfk_pkg::PI_Q30;
      flip = 1;
    end
    x = csfk_pkg::KINF_Q30 + (csfk_pkg::KCORR_Q30 >>> (2 * STAGES));
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      t = x;
      if (ang >= 0) begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        ang -= csfk_pkg::ATAN_Q30[i];
      end else begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        ang += csfk_pkg::ATAN_Q30[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function longint div_round(longint n, longint d);
    longint unsigned un, ud, q;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = (un + ud / 2) / ud;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function logic [16:0] clamp_pos(longint v);
    if (v > csfk_pkg::POS_MAX) v = csfk_pkg::POS_MAX;
    if (v < -csfk_pkg::POS_MAX) v = -csfk_pkg::POS_MAX;
    return v[16:0];
  endfunction

  function logic [15:0] clamp_rot(longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > csfk_pkg::ROT_MAX) r = csfk_pkg::ROT_MAX;
    if (r < -csfk_pkg::ROT_MAX) r = -csfk_pkg::ROT_MAX;
    return r[15:0];
  endfunction

  function void note_input(logic [14:0] bend, logic signed [15:0] plane);
    longint scale, half_pi, st, ct, sd, cd, dev, x, y, z, den, om, cc, ss, sc;
    logic [199:0] p;
    scale = 64'sd1 << (30 - FRAC);
    half_pi = (csfk_pkg::HALF_PI_Q30 + (scale >>> 1)) / scale;
    sin_cos_q30(longint'(bend) * scale, st, ct);
    sin_cos_q30(longint'(plane) * scale, sd, cd);
    dev = longint'(bend) - half_pi;
    if ((dev < 0 ? -dev : dev) <= straight_thr) begin
      x = 0;
      y = 0;
      z = seg_len;
    end else begin
      den = dev * scale;
      om = csfk_pkg::Q30_ONE - st;
      x = -div_round(seg_len * q30_mul(cd, om), den);
      y = div_round(seg_len * q30_mul(sd, om), den);
      z = -div_round(seg_len * ct, den);
    end
    cc = q30_mul(cd, cd);
    ss = q30_mul(sd, sd);
    sc = q30_mul(sd, cd);
    p = '0;
    p[16:0] = clamp_pos(x);
    p[33:17] = clamp_pos(y);
    p[50:34] = clamp_pos(z);
    p[51 +: 16] = clamp_rot(q30_mul(st, cc) + ss);
    p[67 +: 16] = clamp_rot(sc - q30_mul(st, sc));
    p[83 +: 16] = clamp_rot(q30_mul(cd, ct));
    p[99 +: 16] = clamp_rot(sc - q30_mul(st, sc));
    p[115 +: 16] = clamp_rot(q30_mul(st, ss) + cc);
    p[131 +: 16] = clamp_rot(-q30_mul(sd, ct));
    p[147 +: 16] = clamp_rot(-q30_mul(ct, cd));
    p[163 +: 16] = clamp_rot(q30_mul(ct, sd));
    p[179 +: 16] = clamp_rot(st);
    pose_q.push_back(p);
  endfunction

  function void check_result(logic [199:0] got);
    logic [199:0] want;
    string names[12] = '{"tip_x", "tip_y", "tip_z", "rot_00", "rot_01", "rot_02",
                         "rot_10", "rot_11", "rot_12", "rot_20", "rot_21", "rot_22"};
    int lo, w;
    if (pose_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: result %h with nothing expected", got);
      return;
    end
    want = pose_q.pop_front();
    checked++;
    for (int f = 0; f < 12; f++) begin
      lo = f < 3 ? 17 * f : 51 + 16 * (f - 3);
      w = f < 3 ? 17 : 16;
      if (((got ^ want) >> lo) & ((200'd1 << w) - 1)) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d field %s expected %h got %h", checked, names[f],
                   (want >> lo) & ((200'd1 << w) - 1), (got >> lo) & ((200'd1 << w) - 1));
        end
      end
    end
  endfunction
endclass

module testbench;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [199:0] m_tdata;
  logic         cfg_wr_en = 0;
  logic [csfk_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  tip_pose_scoreboard sb = new();
  bit  calm = 0;
  int  hold_off = 0;
  int  sent = 0;
  longint cycles = 0;

  continuum_segment_forward_kinematics_unit u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .cfg_wr_en, .cfg_index, .cfg_data
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL continuum_segment_forward_kinematics_unit");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  initial begin
    int stall;
    stall = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off--;
        m_tready <= 0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9) - 1;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.write_reg(idx, value);
  endtask

  task automatic send_segment(logic [14:0] bend, logic [15:0] plane);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {1'b0, plane, bend};
    do @(posedge clk); while (!s_tready);
    sb.note_input(bend, plane);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pose_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_segments(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_segment(15'($urandom_range(0, 25736)),
                     16'($signed($urandom_range(0, 51472)) - 25736));
      end else if (pick < 9) begin
        send_segment(15'(12868 + $signed($urandom_range(0, 80)) - 40),
                     16'($signed($urandom_range(0, 51472)) - 25736));
      end else begin
        send_segment(15'($urandom()), 16'($urandom()));
      end
    end
  endtask

  initial begin
    logic [14:0] bends[10] = '{0, 32767, 25736, 12868, 12839, 12897, 12838, 12898,
                               16384, 6434};
    logic [15:0] planes[6] = '{16'h8000, 16'h7FFF, 0, 16'd25736, -16'sd25736, 16'd12868};
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed segments at reset settings and then at full length.
    for (int i = 0; i < 10; i++) send_segment(bends[i], planes[i % 6]);
    drain();
    write_reg(csfk_pkg::REG_SEGMENT_LENGTH, 16'hFFFF);
    write_reg(csfk_pkg::REG_STRAIGHT_THRESHOLD, 16'd0);
    for (int i = 0; i < 10; i++) send_segment(bends[i], planes[(i + 3) % 6]);
    send_segment(15'h5555, 16'h2AAA);
    send_segment(15'h2AAA, 16'hD555);
    random_segments(90);
    drain();

    write_reg(csfk_pkg::REG_SEGMENT_LENGTH, 16'd1000);
    write_reg(csfk_pkg::REG_STRAIGHT_THRESHOLD, 16'd8192);
    hold_off = 300;
    random_segments(110);
    drain();

    write_reg(csfk_pkg::REG_SEGMENT_LENGTH, 16'd0);
    write_reg(csfk_pkg::REG_STRAIGHT_THRESHOLD, 16'hFFFF);
    random_segments(100);
    drain();

    write_reg(csfk_pkg::REG_SEGMENT_LENGTH, 16'd65535);
    write_reg(csfk_pkg::REG_STRAIGHT_THRESHOLD, 16'd29);
    random_segments(110);
    drain();

    write_reg(csfk_pkg::REG_SEGMENT_LENGTH, 16'($urandom()));
    write_reg(csfk_pkg::REG_STRAIGHT_THRESHOLD, 16'($urandom_range(0, 100)));
    random_segments(110);
    drain();

    calm = 1;
    write_reg(csfk_pkg::REG_SEGMENT_LENGTH, 16'd25600);
    write_reg(csfk_pkg::REG_STRAIGHT_THRESHOLD, 16'd29);
    random_segments(100);
    drain();

    $display("Sent %0d segment configurations over seven register settings;", sent);
    $display("%0d poses checked, %0d field mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.checked == sent) begin
      $display("PASS continuum_segment_forward_kinematics_unit");
    end else begin
      $display("FAIL continuum_segment_forward_kinematics_unit");
    end
    $finish;
  end

  initial sb.reset_regs();
endmodule

[sim.f]
hw/rtl/csfk_pkg.sv
hw/rtl/csfk_cordic.sv
hw/rtl/csfk_div.sv
hw/rtl/continuum_segment_forward_kinematics_unit.sv
dv/testbench.sv
